// ===== hw/rtl/gsbsf_pkg.sv =====
// shared types and constants of the grid-sampled bright spot finder
`timescale 1ns / 1ps
package gsbsf_pkg;

  localparam int CFG_W    = 13;  // width of each configuration register
  localparam int CFG_IDX_W = 2;
  localparam int LEVEL_W  = 8;
  localparam int OUT_W    = 12;  // width of each mean on the result channel

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_STEP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP     = 2'd3;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SUM,
    ST_DIV,
    ST_HOLD
  } gsbsf_state_t;

  typedef struct packed {
    logic take_pixel;
    logic sum_step;
    logic div_step;
    logic load_out;
  } gsbsf_cmd_t;

  typedef struct packed {
    logic sum_last;
  } gsbsf_status_t;

endpackage

// ===== hw/rtl/gsbsf_ctrl.sv =====
// controller: sequences pixel intake, table summing, mean division and result hand-off
`timescale 1ns / 1ps
module gsbsf_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic                    in_tlast,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  input  gsbsf_pkg::gsbsf_status_t status,
  output gsbsf_pkg::gsbsf_cmd_t    cmd,
  output gsbsf_pkg::gsbsf_state_t  state
);
  import gsbsf_pkg::*;

  gsbsf_state_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (in_tvalid && in_tlast) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (status.sum_last) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_nxt = ST_RUN;
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    in_tready      = 1'b0;
    cmd.take_pixel = 1'b0;
    cmd.sum_step   = 1'b0;
    cmd.div_step   = 1'b0;
    cmd.load_out   = 1'b0;
    case (state_r)
      ST_RUN: begin
        in_tready      = 1'b1;
        cmd.take_pixel = in_tvalid;
      end
      ST_SUM:  cmd.sum_step = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_HOLD: cmd.load_out = out_free;
      default: in_tready = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign state      = state_r;

endmodule

// ===== hw/rtl/gsbsf_dpath.sv =====
// datapath: config registers, grid counters, sorted spot table, summing and mean division
`timescale 1ns / 1ps
module gsbsf_dpath #(
  parameter int SPOT_COUNT = 4,
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [gsbsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsbsf_pkg::CFG_W-1:0]       cfg_data,
  input  logic [gsbsf_pkg::LEVEL_W-1:0]     pixel_level,
  input  logic                              end_of_frame,
  input  gsbsf_pkg::gsbsf_cmd_t             cmd,
  output gsbsf_pkg::gsbsf_status_t          status,
  output logic [gsbsf_pkg::OUT_W-1:0]       mean_x,
  output logic [gsbsf_pkg::OUT_W-1:0]       mean_y
);
  import gsbsf_pkg::*;

  localparam int EW  = (COORD_BITS + 1 > CFG_W) ? COORD_BITS + 1 : CFG_W;
  localparam int KW  = (SPOT_COUNT > 1) ? $clog2(SPOT_COUNT) : 1;
  localparam int LW  = $clog2(SPOT_COUNT);
  localparam int SW  = COORD_BITS + LW;
  localparam int MW  = SW + 1;
  localparam int SH  = SW + LW;
  localparam int PW  = SW + MW;
  localparam logic [EW-1:0] LIMIT   = EW'(1) << COORD_BITS;
  // rounded-up reciprocal, exact for every sum below 2^SW
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SH) + 64'(SPOT_COUNT) - 64'd1) / 64'(SPOT_COUNT);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_FULL);

  function automatic logic [EW-1:0] eff(input logic [CFG_W-1:0] r);
    logic [EW-1:0] v;
    begin
      v = EW'(r);
      if (r == '0) eff = EW'(1);
      else if (v > LIMIT) eff = LIMIT;
      else eff = v;
    end
  endfunction

  // configuration
  logic [CFG_W-1:0] width_r, height_r, col_step_r, row_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= CFG_W'(640);
      height_r   <= CFG_W'(480);
      col_step_r <= CFG_W'(3);
      row_step_r <= CFG_W'(3);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_r    <= cfg_data;
        CFG_FRAME_HEIGHT: height_r   <= cfg_data;
        CFG_COLUMN_STEP:  col_step_r <= cfg_data;
        CFG_ROW_STEP:     row_step_r <= cfg_data;
        default:          width_r    <= width_r;
      endcase
    end
  end

  // grid position counters
  logic [COORD_BITS-1:0] col_cnt_r, col_cnt_nxt, row_cnt_r, row_cnt_nxt;
  logic [COORD_BITS-1:0] col_ph_r, col_ph_nxt, row_ph_r, row_ph_nxt;
  logic [EW-1:0]         col_inc, row_inc, col_ph_inc, row_ph_inc;
  logic                  sampled;

  assign col_inc    = EW'(col_cnt_r) + EW'(1);
  assign row_inc    = EW'(row_cnt_r) + EW'(1);
  assign col_ph_inc = EW'(col_ph_r) + EW'(1);
  assign row_ph_inc = EW'(row_ph_r) + EW'(1);
  assign sampled    = (col_ph_r == '0) && (row_ph_r == '0);

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    col_ph_nxt  = col_ph_r;
    row_ph_nxt  = row_ph_r;
    if (cmd.take_pixel) begin
      if (end_of_frame) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = '0;
        col_ph_nxt  = '0;
        row_ph_nxt  = '0;
      end else if (col_inc >= eff(width_r)) begin
        col_cnt_nxt = '0;
        col_ph_nxt  = '0;
        if (row_inc >= eff(height_r)) begin
          row_cnt_nxt = '0;
          row_ph_nxt  = '0;
        end else begin
          row_cnt_nxt = COORD_BITS'(row_inc);
          row_ph_nxt  = (row_ph_inc >= eff(row_step_r)) ? '0 : COORD_BITS'(row_ph_inc);
        end
      end else begin
        col_cnt_nxt = COORD_BITS'(col_inc);
        col_ph_nxt  = (col_ph_inc >= eff(col_step_r)) ? '0 : COORD_BITS'(col_ph_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      col_ph_r  <= '0;
      row_ph_r  <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      col_ph_r  <= col_ph_nxt;
      row_ph_r  <= row_ph_nxt;
    end
  end

  // spot table, brightest first; registered compare-and-shift insert
  logic [LEVEL_W-1:0]    lvl_r [SPOT_COUNT];
  logic [COORD_BITS-1:0] scol_r[SPOT_COUNT];
  logic [COORD_BITS-1:0] srow_r[SPOT_COUNT];
  logic [LEVEL_W-1:0]    lvl_nxt [SPOT_COUNT];
  logic [COORD_BITS-1:0] scol_nxt[SPOT_COUNT];
  logic [COORD_BITS-1:0] srow_nxt[SPOT_COUNT];
  logic [SPOT_COUNT-1:0] keep;
  logic                  enter;

  assign enter = cmd.take_pixel && sampled && (pixel_level > lvl_r[SPOT_COUNT-1]);

  always_comb begin
    for (int k = 0; k < SPOT_COUNT; k++) begin
      keep[k]     = lvl_r[k] >= pixel_level;
      lvl_nxt[k]  = lvl_r[k];
      scol_nxt[k] = scol_r[k];
      srow_nxt[k] = srow_r[k];
      if (cmd.sum_step && status.sum_last) begin
        lvl_nxt[k]  = '0;
        scol_nxt[k] = '0;
        srow_nxt[k] = '0;
      end else if (enter && !keep[k]) begin
        if (k == 0 || keep[(k > 0) ? k - 1 : 0]) begin
          lvl_nxt[k]  = pixel_level;
          scol_nxt[k] = col_cnt_r;
          srow_nxt[k] = row_cnt_r;
        end else begin
          lvl_nxt[k]  = lvl_r[(k > 0) ? k - 1 : 0];
          scol_nxt[k] = scol_r[(k > 0) ? k - 1 : 0];
          srow_nxt[k] = srow_r[(k > 0) ? k - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SPOT_COUNT; k++) begin
        lvl_r[k]  <= '0;
        scol_r[k] <= '0;
        srow_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < SPOT_COUNT; k++) begin
        lvl_r[k]  <= lvl_nxt[k];
        scol_r[k] <= scol_nxt[k];
        srow_r[k] <= srow_nxt[k];
      end
    end
  end

  // one entry per cycle into the sums, then a reciprocal
  // multiplication divides both sums by the spot count
  logic [KW-1:0] k_r;
  logic [SW-1:0] acc_x_r, acc_y_r;
  logic [PW-1:0] prod_x, prod_y;

  assign prod_x = PW'(acc_x_r) * PW'(RECIP);
  assign prod_y = PW'(acc_y_r) * PW'(RECIP);

  assign status.sum_last = (k_r == KW'(SPOT_COUNT - 1));

  always_ff @(posedge clk) begin
    if (cmd.take_pixel && end_of_frame) begin
      k_r     <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (cmd.sum_step) begin
      k_r     <= k_r + KW'(1);
      acc_x_r <= acc_x_r + SW'(scol_r[k_r]);
      acc_y_r <= acc_y_r + SW'(srow_r[k_r]);
    end else if (cmd.div_step) begin
      acc_x_r <= SW'(prod_x[SH +: COORD_BITS]);
      acc_y_r <= SW'(prod_y[SH +: COORD_BITS]);
    end
  end

  // result register
  logic [OUT_W-1:0] mean_x_r, mean_y_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mean_x_r <= OUT_W'(acc_x_r);
      mean_y_r <= OUT_W'(acc_y_r);
    end
  end

  assign mean_x = mean_x_r;
  assign mean_y = mean_y_r;

endmodule

// ===== hw/rtl/grid_sampled_bright_spot_finder.sv =====
// top level of the grid-sampled bright spot finder
`timescale 1ns / 1ps
// Takes one pixel level per clock in raster order and keeps the SPOT_COUNT
// brightest pixels that fall on the column_step by row_step sampling grid.
// Ordinary pixels are taken one a cycle with no stall. On the pixel marked
// with tlast the block stops taking pixels for the table summing in ST_SUM
// (one entry a cycle), then ST_DIV divides both sums by SPOT_COUNT
// through a reciprocal multiplication, then ST_HOLD loads the result
// register, which must be free. The input is therefore closed from a frame
// end request until the result is loaded, including any wait for the
// previous result to be taken. The result carries the truncated mean column
// and row of the table, and the table is cleared for the next frame.
// Configuration requests are always taken and act at once.
module grid_sampled_bright_spot_finder #(
  parameter int SPOT_COUNT = 4,
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gsbsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gsbsf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] pixel_level
  input  logic                            in_tlast,   // end_of_frame
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata   // [11:0] mean_x, [23:12] mean_y
);
  import gsbsf_pkg::*;

  gsbsf_cmd_t       cmd;
  gsbsf_status_t    status;
  gsbsf_state_t     state;
  logic [OUT_W-1:0] mean_x, mean_y;

  assign cfg_ready = 1'b1;

  gsbsf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd),
    .state      (state)
  );

  gsbsf_dpath #(
    .SPOT_COUNT (SPOT_COUNT),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_level  (in_tdata[LEVEL_W-1:0]),
    .end_of_frame (in_tlast),
    .cmd          (cmd),
    .status       (status),
    .mean_x       (mean_x),
    .mean_y       (mean_y)
  );

  assign out_tdata = {mean_y, mean_x};

  // a frame end request always closes the input for the summing pass
  a_eof_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready && state == ST_SUM)
    else $error("input still open after frame end");

  // a new result is only loaded from the hold state, never while pixels flow
  a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready) && $past(state) == ST_HOLD)
    else $error("result loaded outside hold state");

  // the division state is followed directly by the hold state
  a_div_then_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state == ST_DIV |=> state == ST_HOLD)
    else $error("division not followed by hold");

endmodule

// ===== sim/grid_sampled_bright_spot_finder_tb.sv =====
// self-checking testbench for the grid-sampled bright spot finder
`timescale 1ns / 1ps
module grid_sampled_bright_spot_finder_tb;
  import gsbsf_pkg::*;

  localparam int SPOTS        = 4;
  localparam int COORD_BITS   = 12;
  localparam int COORD_LIMIT  = 1 << COORD_BITS;
  localparam int SETTLE       = 40;      // margin for a frame end to finish
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 500;
  localparam int LIMIT        = 400000;
  localparam int DIR_ROWS     = 38;

  typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_W-1:0]       reg_val;
    logic [LEVEL_W-1:0]     level;
    logic                   eof;
    logic                   pinned;   // expected means typed in below
    logic [OUT_W-1:0]       want_x;
    logic [OUT_W-1:0]       want_y;
  } stim_row_t;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
  } centroid_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;   // [7:0] pixel_level
  logic                 in_tlast;   // end_of_frame
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;  // [11:0] mean_x, [23:12] mean_y

  // model of the block
  logic [CFG_W-1:0] reg_w, reg_h, reg_cs, reg_rs;
  int unsigned      col_pos, row_pos, col_ph, row_ph;
  int unsigned      spot_lvl [SPOTS];
  int unsigned      spot_col [SPOTS];
  int unsigned      spot_row [SPOTS];

  centroid_t centroid_q [$];
  int        mismatches;
  int        cycles;
  bit        steady;
  bit        hold_request;

  stim_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd0, 1'b1, 1'b1, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd255, 1'b1, 1'b1, 12'd0, 12'd0},
    '{ROW_CFG, CFG_FRAME_WIDTH, 13'd4, 8'd0, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_CFG, CFG_FRAME_HEIGHT, 13'd4, 8'd0, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_CFG, CFG_COLUMN_STEP, 13'd1, 8'd0, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_CFG, CFG_ROW_STEP, 13'd1, 8'd0, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd1, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd2, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd3, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd4, 1'b1, 1'b1, 12'd1, 12'd0},
    // equal levels: the fifth one stays out
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd7, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd7, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd7, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd7, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd7, 1'b1, 1'b1, 12'd1, 12'd0},
    // one column, four rows: the last two pixels wrap to rows 0 and 1
    '{ROW_CFG, CFG_FRAME_WIDTH, 13'd1, 8'd0, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd5, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd6, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd7, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd8, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd9, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd10, 1'b1, 1'b1, 12'd0, 12'd1},
    // zero steps and size, oversize height
    '{ROW_CFG, CFG_COLUMN_STEP, 13'd0, 8'd0, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_CFG, CFG_ROW_STEP, 13'd0, 8'd0, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_CFG, CFG_FRAME_WIDTH, 13'd0, 8'd0, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_CFG, CFG_FRAME_HEIGHT, 13'd8191, 8'd0, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd200, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd100, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd50, 1'b1, 1'b0, 12'd0, 12'd0},
    // oversize column step, then a step change in the middle of a frame
    '{ROW_CFG, CFG_FRAME_WIDTH, 13'd8, 8'd0, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_CFG, CFG_COLUMN_STEP, 13'd5000, 8'd0, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd40, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd41, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd42, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_CFG, CFG_COLUMN_STEP, 13'd2, 8'd0, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd43, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd44, 1'b0, 1'b0, 12'd0, 12'd0},
    '{ROW_PIXEL, CFG_FRAME_WIDTH, 13'd0, 8'd45, 1'b1, 1'b0, 12'd0, 12'd0}
  };

  grid_sampled_bright_spot_finder #(
    .SPOT_COUNT (SPOTS),
    .COORD_BITS (COORD_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // register value as the counters see it
  function automatic int unsigned span(input logic [CFG_W-1:0] r);
    if (r == 0) return 1;
    if (r > COORD_LIMIT) return COORD_LIMIT;
    return r;
  endfunction

  // steps the model by one pixel; returns 1 with the means on a frame end
  function automatic bit track_pixel(input logic [7:0] level, input logic eof,
                                     output centroid_t mean);
    int pos;
    int unsigned sx, sy;
    mean = '0;
    if (col_ph == 0 && row_ph == 0 && level > spot_lvl[SPOTS-1]) begin
      pos = 0;
      while (pos < SPOTS - 1 && spot_lvl[pos] >= level) pos++;
      for (int k = SPOTS - 1; k > pos; k--) begin
        spot_lvl[k] = spot_lvl[k-1];
        spot_col[k] = spot_col[k-1];
        spot_row[k] = spot_row[k-1];
      end
      spot_lvl[pos] = level;
      spot_col[pos] = col_pos;
      spot_row[pos] = row_pos;
    end
    if (eof) begin
      sx = 0;
      sy = 0;
      for (int k = 0; k < SPOTS; k++) begin
        sx += spot_col[k];
        sy += spot_row[k];
        spot_lvl[k] = 0;
        spot_col[k] = 0;
        spot_row[k] = 0;
      end
      mean.x = OUT_W'(sx / SPOTS);
      mean.y = OUT_W'(sy / SPOTS);
      col_pos = 0;
      row_pos = 0;
      col_ph  = 0;
      row_ph  = 0;
      return 1'b1;
    end
    if (col_pos + 1 >= span(reg_w)) begin
      col_pos = 0;
      col_ph  = 0;
      if (row_pos + 1 >= span(reg_h)) begin
        row_pos = 0;
        row_ph  = 0;
      end else begin
        row_pos++;
        row_ph = (row_ph + 1 >= span(reg_rs)) ? 0 : row_ph + 1;
      end
    end else begin
      col_pos++;
      col_ph = (col_ph + 1 >= span(reg_cs)) ? 0 : col_ph + 1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic wait_drained();
    while (centroid_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] level, input logic eof, input logic pinned,
                            input logic [OUT_W-1:0] px, input logic [OUT_W-1:0] py);
    int        gap;
    centroid_t mean;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= level;
    in_tlast  <= eof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (track_pixel(level, eof, mean))
      centroid_q.push_back(pinned ? centroid_t'{px, py} : mean);
  endtask

  // only written with nothing in flight
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  reg_w  = val;
      CFG_FRAME_HEIGHT: reg_h  = val;
      CFG_COLUMN_STEP:  reg_cs = val;
      CFG_ROW_STEP:     reg_rs = val;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] draw_level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(1, 4) * 50);  // repeats give equal levels
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] draw_size(input int unsigned typical);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return CFG_W'(COORD_LIMIT);
      2:       return '1;
      3:       return CFG_W'($urandom_range(0, 8191));
      default: return CFG_W'($urandom_range(1, typical));
    endcase
  endfunction

  // result side: random stalls, and one long hold-off on request
  initial begin
    int stall;
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid && !hold_request) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (centroid_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result x %0d y %0d",
                                  out_tdata[11:0], out_tdata[23:12]));
      end else begin
        centroid_t want;
        want = centroid_q.pop_front();
        if (out_tdata[11:0] !== want.x)
          report_mismatch($sformatf("mean_x %0d, expected %0d", out_tdata[11:0], want.x));
        if (out_tdata[23:12] !== want.y)
          report_mismatch($sformatf("mean_y %0d, expected %0d", out_tdata[23:12], want.y));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("grid_sampled_bright_spot_finder_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int frames, len, random_items;
    bit leave_open;
    rst_n        <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tlast     <= 1'b0;
    mismatches   = 0;
    cycles       = 0;
    steady       = 1'b0;
    hold_request = 1'b0;
    random_items = 0;
    reg_w   = 13'd640;
    reg_h   = 13'd480;
    reg_cs  = 13'd3;
    reg_rs  = 13'd3;
    col_pos = 0;
    row_pos = 0;
    col_ph  = 0;
    row_ph  = 0;
    for (int k = 0; k < SPOTS; k++) begin
      spot_lvl[k] = 0;
      spot_col[k] = 0;
      spot_row[k] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_register(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      else
        send_pixel(directed_rows[i].level, directed_rows[i].eof, directed_rows[i].pinned,
                   directed_rows[i].want_x, directed_rows[i].want_y);
    end

    // single-pixel frames against a held result channel so the input backs up
    write_register(CFG_FRAME_WIDTH, 13'd3);
    write_register(CFG_FRAME_HEIGHT, 13'd3);
    write_register(CFG_COLUMN_STEP, 13'd1);
    write_register(CFG_ROW_STEP, 13'd1);
    hold_request = 1'b1;
    repeat (8) send_pixel(draw_level(), 1'b1, 1'b0, '0, '0);
    in_tvalid <= 1'b0;
    wait_drained();

    while (random_items < RANDOM_ITEMS) begin
      write_register(CFG_FRAME_WIDTH, draw_size(12));
      write_register(CFG_FRAME_HEIGHT, draw_size(8));
      write_register(CFG_COLUMN_STEP, draw_size(4));
      write_register(CFG_ROW_STEP, draw_size(4));
      steady     = ($urandom_range(0, 5) == 0);
      frames     = $urandom_range(1, 4);
      leave_open = ($urandom_range(0, 4) == 0);  // next writes land mid-frame
      for (int f = 0; f < frames; f++) begin
        len = $urandom_range(1, 24);
        for (int n = 0; n < len; n++) begin
          send_pixel(draw_level(), n == len - 1 && !(leave_open && f == frames - 1),
                     1'b0, '0, '0);
          random_items++;
        end
      end
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && centroid_q.size() == 0) begin
      $display("grid_sampled_bright_spot_finder_tb OK");
    end else begin
      $display("grid_sampled_bright_spot_finder_tb NOT OK");
    end
    $finish;
  end

endmodule
